/* hw/rtl/tfe_pkg.sv */
// ----------------------------------------------------------------------------
// tfe_pkg
// Shared constants, types and helpers for the telemetry frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tfe_pkg;

  localparam int FRAME_LEN  = 19;
  localparam int CNT_W      = $clog2(FRAME_LEN + 1);
  localparam int VAL_W      = 14;
  localparam int FULL_SCALE = 16383;
  localparam int MID_OFFSET = 8192;
  localparam int COEF_W     = 28;
  localparam int NUM_SCALED = 7;

  localparam int ANGLE_W = 16;
  localparam int SPEED_W = 16;
  localparam int ACCEL_W = 17;

  localparam int K_ANGLE = 2982252;
  localparam int K_SPEED = 11929736;
  localparam int K_ACCEL = 134201344;

  localparam int FRAC_ANGLE = 23;
  localparam int FRAC_SPEED = 24;
  localparam int FRAC_ACCEL = 28;

  localparam logic [7:0] END_BYTE      = 8'hFF;
  localparam logic [7:0] BTN1_MASK     = 8'hFB;
  localparam logic [7:0] BTN2_MASK     = 8'h7B;
  localparam logic [7:0] BTN_MOVE_MASK = 8'h04;

  typedef struct packed {
    logic active;
    logic last;
    logic near_done;
  } ser_status_t;

  // floor(x * 0.9961) for an 8-bit x is x - 1, except zero; never above 254
  function automatic logic [7:0] stick_scale(input logic [7:0] raw);
    logic [7:0] res;
    res = (raw == 8'd0) ? 8'd0 : raw - 8'd1;
    return res;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/telemetry_frame_encoder_top.sv */
// ----------------------------------------------------------------------------
// telemetry_frame_encoder_top
// Scales one telemetry sample in parallel lanes and sends it as a 19-byte frame.
//
//   channel   handshake         payload
//   input     start / busy      angle_x .. stick_y
//   output    strobe            frame_byte, last_byte
//
// an accepted item is registered in the lane products and lane_valid, then loaded
// into the frame register; its nineteen bytes follow on consecutive cycles, sent by
// the one-byte-per-cycle frame shifter; a new item is taken before the last frame ends
// busy drops before the shifter runs dry, so frames follow gap-free
// rst clears the lane-valid flag and the byte counter; the receiver cannot stall
// ----------------------------------------------------------------------------
`default_nettype none

module telemetry_frame_encoder_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] angle_x,
  input  wire logic signed [15:0] angle_y,
  input  wire logic signed [15:0] speed_left,
  input  wire logic signed [15:0] speed_right,
  input  wire logic signed [16:0] accel_x,
  input  wire logic signed [16:0] accel_y,
  input  wire logic signed [16:0] accel_z,
  input  wire logic [7:0]         buttons_first,
  input  wire logic [7:0]         buttons_second,
  input  wire logic [7:0]         stick_x,
  input  wire logic [7:0]         stick_y,
  output logic                    strobe,
  output logic [7:0]              frame_byte,
  output logic                    last_byte
);
  import tfe_pkg::*;

  logic                                take;
  logic                                lane_valid;
  logic [7:0]                          btn1;
  logic [7:0]                          btn2;
  logic [7:0]                          stk_x;
  logic [7:0]                          stk_y;
  logic [NUM_SCALED-1:0][VAL_W-1:0]    vals;
  ser_status_t                         status;

  assign take = start & ~busy;
  assign busy = lane_valid | ~status.near_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
    end else begin
      lane_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      btn1  <= buttons_first;
      btn2  <= buttons_second;
      stk_x <= stick_x;
      stk_y <= stick_y;
    end
  end

  tfe_scale_lane #(.IN_W(ANGLE_W), .COEF(K_ANGLE), .FRAC(FRAC_ANGLE), .OFFSET_EN(1'b1))
    u_lane_ang_x (.clk(clk), .en(take), .raw(angle_x), .value(vals[0]));
  tfe_scale_lane #(.IN_W(ANGLE_W), .COEF(K_ANGLE), .FRAC(FRAC_ANGLE), .OFFSET_EN(1'b1))
    u_lane_ang_y (.clk(clk), .en(take), .raw(angle_y), .value(vals[1]));
  tfe_scale_lane #(.IN_W(SPEED_W), .COEF(K_SPEED), .FRAC(FRAC_SPEED), .OFFSET_EN(1'b0))
    u_lane_spd_l (.clk(clk), .en(take), .raw(speed_left), .value(vals[2]));
  tfe_scale_lane #(.IN_W(SPEED_W), .COEF(K_SPEED), .FRAC(FRAC_SPEED), .OFFSET_EN(1'b0))
    u_lane_spd_r (.clk(clk), .en(take), .raw(speed_right), .value(vals[3]));
  tfe_scale_lane #(.IN_W(ACCEL_W), .COEF(K_ACCEL), .FRAC(FRAC_ACCEL), .OFFSET_EN(1'b1))
    u_lane_acc_x (.clk(clk), .en(take), .raw(accel_x), .value(vals[4]));
  tfe_scale_lane #(.IN_W(ACCEL_W), .COEF(K_ACCEL), .FRAC(FRAC_ACCEL), .OFFSET_EN(1'b1))
    u_lane_acc_y (.clk(clk), .en(take), .raw(accel_y), .value(vals[5]));
  tfe_scale_lane #(.IN_W(ACCEL_W), .COEF(K_ACCEL), .FRAC(FRAC_ACCEL), .OFFSET_EN(1'b1))
    u_lane_acc_z (.clk(clk), .en(take), .raw(accel_z), .value(vals[6]));

  tfe_frame_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .load   (lane_valid),
    .vals   (vals),
    .btn1   (btn1),
    .btn2   (btn2),
    .stk_x  (stk_x),
    .stk_y  (stk_y),
    .head   (frame_byte),
    .status (status)
  );

  assign strobe    = status.active;
  assign last_byte = status.last;

`ifndef SYNTHESIS
  a_first_byte: assert property (@(posedge clk) disable iff (rst)
    take |-> ##2 (strobe && !last_byte))
    else $error("frame did not start two cycles after accept");

  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_byte) |-> (frame_byte == END_BYTE))
    else $error("end marker byte wrong");

  a_data_byte: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_byte) |-> (frame_byte != END_BYTE))
    else $error("data byte equals end marker");

  a_last_in_frame: assert property (@(posedge clk) disable iff (rst)
    last_byte |-> strobe)
    else $error("last_byte without strobe");
`endif

endmodule

`default_nettype wire

/* hw/rtl/tfe_scale_lane.sv */
// ----------------------------------------------------------------------------
// tfe_scale_lane
// One scaling lane: registered multiply, then optional offset, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module tfe_scale_lane #(
  parameter int IN_W      = tfe_pkg::ANGLE_W,
  parameter int COEF      = tfe_pkg::K_ANGLE,
  parameter int FRAC      = tfe_pkg::FRAC_ANGLE,
  parameter bit OFFSET_EN = 1'b1
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic signed [IN_W-1:0]     raw,
  output logic [tfe_pkg::VAL_W-1:0]       value
);
  import tfe_pkg::*;

  localparam int PW = IN_W + COEF_W + 1;
  localparam int SW = PW + 1;
  localparam longint BIAS_L = (OFFSET_EN ? (longint'(MID_OFFSET) <<< FRAC) : 64'sd0)
                              + (longint'(1) <<< (FRAC - 1));
  localparam logic signed [SW-1:0] BIAS = SW'(BIAS_L);

  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] sum;
  logic [SW-FRAC-1:0]   whole;
  logic                 over;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'(raw) * PW'($signed({1'b0, COEF_W'(COEF)}));
    end
  end

  always_comb begin
    sum   = $signed({prod[PW-1], prod}) + BIAS;
    whole = sum[SW-1:FRAC];
    over  = |whole[SW-FRAC-2:VAL_W];
    if (sum[SW-1]) begin
      value = '0;
    end else if (over) begin
      value = VAL_W'(FULL_SCALE);
    end else begin
      value = whole[VAL_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tfe_frame_merge.sv */
// ----------------------------------------------------------------------------
// tfe_frame_merge
// Merges the lane results, buttons and sticks into a 19-byte frame and shifts it out byte by byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tfe_frame_merge (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         load,
  input  wire logic [tfe_pkg::NUM_SCALED-1:0][tfe_pkg::VAL_W-1:0] vals,
  input  wire logic [7:0]                                   btn1,
  input  wire logic [7:0]                                   btn2,
  input  wire logic [7:0]                                   stk_x,
  input  wire logic [7:0]                                   stk_y,
  output logic [7:0]                                        head,
  output tfe_pkg::ser_status_t                              status
);
  import tfe_pkg::*;

  logic [7:0]       frame [FRAME_LEN];
  logic [7:0]       frame_next [FRAME_LEN];
  logic [CNT_W-1:0] rem;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      frame_next[2*i]   = {vals[i][VAL_W-1:7], 1'b0};
      frame_next[2*i+1] = {1'b0, vals[i][6:0]};
    end
    frame_next[8] = btn1 & BTN1_MASK;
    frame_next[9] = (btn2 & BTN2_MASK) | (btn1 & BTN_MOVE_MASK);
    for (int i = 0; i < 3; i++) begin
      frame_next[10+2*i] = {vals[4+i][VAL_W-1:7], 1'b0};
      frame_next[11+2*i] = {1'b0, vals[4+i][6:0]};
    end
    frame_next[16] = stick_scale(stk_x);
    frame_next[17] = stick_scale(stk_y);
    frame_next[18] = END_BYTE;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= frame_next;
    end else if (rem != '0) begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
        frame[i] <= frame[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= CNT_W'(FRAME_LEN);
    end else if (rem != '0) begin
      rem <= rem - CNT_W'(1);
    end
  end

  assign head             = frame[0];
  assign status.active    = (rem != '0);
  assign status.last      = (rem == CNT_W'(1));
  assign status.near_done = (rem <= CNT_W'(2));

endmodule

`default_nettype wire

/* test/telemetry_frame_encoder_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_frame_encoder_top_tb
// Sends telemetry samples through the start/busy port and checks every byte of
// each nineteen-byte frame against frames built in the bench from the same
// samples. Directed samples cover the field extremes, clamping, saturation,
// the button bit move and the joystick cap. A few hundred random samples
// follow, first back to back and then with random gaps.
// ----------------------------------------------------------------------------

module telemetry_frame_encoder_top_tb;

  localparam int          FRAME_BYTES = 19;
  localparam int          TOP_CODE    = 16383;
  localparam longint      ANGLE_GAIN  = 2982252;
  localparam longint      SPEED_GAIN  = 11929736;
  localparam longint      ACCEL_GAIN  = 134201344;
  localparam int          ANGLE_FRAC  = 23;
  localparam int          SPEED_FRAC  = 24;
  localparam int          ACCEL_FRAC  = 28;
  localparam logic [7:0]  FRAME_END   = 8'hFF;
  localparam int          STICK_MAX   = 254;
  localparam int          RANDOM_ITEMS = 360;
  localparam int          BURST_ITEMS  = 120;
  localparam int          MAX_GAP      = 40;
  localparam int          CYCLE_LIMIT  = 200000;

  typedef struct {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] speed_left;
    logic signed [15:0] speed_right;
    logic signed [16:0] accel_x;
    logic signed [16:0] accel_y;
    logic signed [16:0] accel_z;
    logic [7:0]         buttons_first;
    logic [7:0]         buttons_second;
    logic [7:0]         stick_x;
    logic [7:0]         stick_y;
  } sample_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_entry_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] angle_x = '0;
  logic signed [15:0] angle_y = '0;
  logic signed [15:0] speed_left = '0;
  logic signed [15:0] speed_right = '0;
  logic signed [16:0] accel_x = '0;
  logic signed [16:0] accel_y = '0;
  logic signed [16:0] accel_z = '0;
  logic [7:0]         buttons_first = '0;
  logic [7:0]         buttons_second = '0;
  logic [7:0]         stick_x = '0;
  logic [7:0]         stick_y = '0;
  logic               strobe;
  logic [7:0]         frame_byte;
  logic               last_byte;

  frame_entry_t frame_due_q[$];
  int           error_count = 0;
  bit           gaps_on = 1'b0;

  telemetry_frame_encoder_top uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .angle_x        (angle_x),
    .angle_y        (angle_y),
    .speed_left     (speed_left),
    .speed_right    (speed_right),
    .accel_x        (accel_x),
    .accel_y        (accel_y),
    .accel_z        (accel_z),
    .buttons_first  (buttons_first),
    .buttons_second (buttons_second),
    .stick_x        (stick_x),
    .stick_y        (stick_y),
    .strobe         (strobe),
    .frame_byte     (frame_byte),
    .last_byte      (last_byte)
  );

  always #1 clk = ~clk;

  // scaled, optionally offset, rounded half up and saturated 14-bit code
  function automatic logic [13:0] scale_code(longint raw, longint gain, int frac,
                                             bit centered);
    longint prod;
    prod = raw * gain;
    if (centered) prod = prod + (64'sd8192 <<< frac);
    prod = prod + (64'sd1 <<< (frac - 1));
    if (prod < 0) return '0;
    prod = prod >>> frac;
    if (prod > TOP_CODE) return 14'(TOP_CODE);
    return prod[13:0];
  endfunction

  function automatic logic [7:0] stick_code(logic [7:0] raw);
    int v;
    v = (int'(raw) * 9961) / 10000;
    if (v > STICK_MAX) v = STICK_MAX;
    return v[7:0];
  endfunction

  function automatic void push_byte(logic [7:0] data, logic last);
    frame_entry_t e;
    e.data = data;
    e.last = last;
    frame_due_q.push_back(e);
  endfunction

  function automatic void push_pair(logic [13:0] code);
    push_byte({code[13:7], 1'b0}, 1'b0);
    push_byte({1'b0, code[6:0]}, 1'b0);
  endfunction

  function automatic void encode_frame(sample_t s);
    push_pair(scale_code(longint'(s.angle_x), ANGLE_GAIN, ANGLE_FRAC, 1'b1));
    push_pair(scale_code(longint'(s.angle_y), ANGLE_GAIN, ANGLE_FRAC, 1'b1));
    push_pair(scale_code(longint'(s.speed_left), SPEED_GAIN, SPEED_FRAC, 1'b0));
    push_pair(scale_code(longint'(s.speed_right), SPEED_GAIN, SPEED_FRAC, 1'b0));
    push_byte(s.buttons_first & 8'hFB, 1'b0);
    push_byte((s.buttons_second & 8'h7B) | (s.buttons_first & 8'h04), 1'b0);
    push_pair(scale_code(longint'(s.accel_x), ACCEL_GAIN, ACCEL_FRAC, 1'b1));
    push_pair(scale_code(longint'(s.accel_y), ACCEL_GAIN, ACCEL_FRAC, 1'b1));
    push_pair(scale_code(longint'(s.accel_z), ACCEL_GAIN, ACCEL_FRAC, 1'b1));
    push_byte(stick_code(s.stick_x), 1'b0);
    push_byte(stick_code(s.stick_y), 1'b0);
    push_byte(FRAME_END, 1'b1);
  endfunction

  // half over the full range, half within +/- span around zero
  function automatic logic [16:0] pick_signed(int width, int span);
    int v;
    if ($urandom_range(1)) v = int'($urandom_range((1 << width) - 1)) - (1 << (width - 1));
    else v = int'($urandom_range(2 * span)) - span;
    return v[16:0];
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.angle_x        = 16'(pick_signed(16, 23100));
    s.angle_y        = 16'(pick_signed(16, 23100));
    s.speed_left     = 16'(pick_signed(16, 23100));
    s.speed_right    = 16'(pick_signed(16, 23100));
    s.accel_x        = pick_signed(17, 16500);
    s.accel_y        = pick_signed(17, 16500);
    s.accel_z        = pick_signed(17, 16500);
    s.buttons_first  = 8'($urandom);
    s.buttons_second = 8'($urandom);
    s.stick_x        = 8'($urandom);
    s.stick_y        = 8'($urandom);
    return s;
  endfunction

  // start stays high when the next item follows at once
  task automatic send_sample(sample_t s);
    start          <= 1'b1;
    angle_x        <= s.angle_x;
    angle_y        <= s.angle_y;
    speed_left     <= s.speed_left;
    speed_right    <= s.speed_right;
    accel_x        <= s.accel_x;
    accel_y        <= s.accel_y;
    accel_z        <= s.accel_z;
    buttons_first  <= s.buttons_first;
    buttons_second <= s.buttons_second;
    stick_x        <= s.stick_x;
    stick_y        <= s.stick_y;
    @(posedge clk);
    while (busy) @(posedge clk);
    encode_frame(s);
    if (gaps_on && $urandom_range(99) < 30) begin
      sample_t junk;
      junk = random_sample();
      start          <= 1'b0;
      angle_x        <= junk.angle_x;
      accel_z        <= junk.accel_z;
      buttons_first  <= junk.buttons_first;
      stick_y        <= junk.stick_y;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    frame_entry_t e;
    if (!rst && strobe) begin
      if (frame_due_q.size() == 0) begin
        $error("frame_byte: unexpected byte %02h", frame_byte);
        error_count++;
      end else begin
        e = frame_due_q.pop_front();
        if (frame_byte !== e.data) begin
          $error("frame_byte: expected %02h, got %02h", e.data, frame_byte);
          error_count++;
        end
        if (last_byte !== e.last) begin
          $error("last_byte: expected %0b, got %0b", e.last, last_byte);
          error_count++;
        end
      end
    end
  end

  task automatic test_extremes();
    sample_t s;
    s = '{default: '0};
    send_sample(s);
    s = '{angle_x: 16'sh8000, angle_y: 16'sh8000, speed_left: 16'sh8000,
          speed_right: 16'sh8000, accel_x: 17'sh10000, accel_y: 17'sh10000,
          accel_z: 17'sh10000, default: '0};
    send_sample(s);
    s = '{angle_x: 16'sh7FFF, angle_y: 16'sh7FFF, speed_left: 16'sh7FFF,
          speed_right: 16'sh7FFF, accel_x: 17'shFFFF, accel_y: 17'shFFFF,
          accel_z: 17'shFFFF, default: 8'hFF};
    send_sample(s);
  endtask

  task automatic test_clamp_and_saturate();
    sample_t s;
    // band edges: just inside and just past both ends
    s = '{angle_x: -16'sd23040, angle_y: 16'sd23040, speed_left: -16'sd1,
          speed_right: 16'sd23000, accel_x: -17'sd16384, accel_y: 17'sd16384,
          accel_z: 17'sd16385, default: '0};
    send_sample(s);
    s = '{angle_x: -16'sd23100, angle_y: 16'sd23100, speed_left: 16'sd23100,
          speed_right: -16'sd200, accel_x: -17'sd16500, accel_y: 17'sd16500,
          accel_z: -17'sd16383, default: '0};
    send_sample(s);
    // rounding near the half step
    s = '{angle_x: 16'sd1, angle_y: -16'sd1, speed_left: 16'sd1, speed_right: 16'sd3,
          accel_x: 17'sd1, accel_y: -17'sd1, accel_z: 17'sd3, default: '0};
    send_sample(s);
    s = '{angle_x: 16'sd2, angle_y: -16'sd3, speed_left: 16'sd2, speed_right: 16'sd5,
          accel_x: -17'sd3, accel_y: 17'sd2, accel_z: -17'sd2, default: '0};
    send_sample(s);
  endtask

  task automatic test_buttons();
    sample_t s;
    s = '{buttons_first: 8'h04, buttons_second: 8'h00, default: '0};
    send_sample(s);
    s = '{buttons_first: 8'hFB, buttons_second: 8'hFF, default: '0};
    send_sample(s);
    s = '{buttons_first: 8'hFF, buttons_second: 8'h84, default: '0};
    send_sample(s);
    s = '{buttons_first: 8'h00, buttons_second: 8'h7B, default: '0};
    send_sample(s);
  endtask

  task automatic test_sticks();
    sample_t s;
    s = '{stick_x: 8'd0, stick_y: 8'd255, default: '0};
    send_sample(s);
    s = '{stick_x: 8'd1, stick_y: 8'd254, default: '0};
    send_sample(s);
    s = '{stick_x: 8'd255, stick_y: 8'd0, default: '0};
    send_sample(s);
    s = '{stick_x: 8'd128, stick_y: 8'd2, default: '0};
    send_sample(s);
  endtask

  task automatic test_random();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = (n >= BURST_ITEMS);
      send_sample(random_sample());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_clamp_and_saturate();
    test_buttons();
    test_sticks();
    test_random();
    start <= 1'b0;
    while (frame_due_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* telemetry_frame_encoder_top.f */
hw/rtl/tfe_pkg.sv
hw/rtl/tfe_scale_lane.sv
hw/rtl/tfe_frame_merge.sv
hw/rtl/telemetry_frame_encoder_top.sv
test/telemetry_frame_encoder_top_tb.sv
